// File: hdl/tmpg_pkg.sv
// Package for the text mode pixel generator: geometry constants, mode codes,
// default palette and the pipeline stage records. No dependencies.
`default_nettype none

package tmpg_pkg;

  // Screen geometry in character cells.
  localparam int CELL_COLUMNS = 32;
  localparam int CELL_ROWS    = 12;
  localparam int GLYPH_COUNT  = 128;

  localparam int CELL_TOTAL    = CELL_COLUMNS * CELL_ROWS;
  localparam int GLYPH_WORDS   = 2 * GLYPH_COUNT;
  localparam int PIXEL_COLUMNS = 4 * CELL_COLUMNS;
  localparam int PIXEL_ROWS    = 8 * CELL_ROWS;
  localparam int PALETTE_SIZE  = 16;

  localparam int CELL_AW  = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int GLYPH_AW = $clog2(GLYPH_WORDS);
  localparam int COL_W    = $clog2(PIXEL_COLUMNS);
  localparam int ROW_W    = $clog2(PIXEL_ROWS);
  localparam int CCOL_W   = (CELL_COLUMNS > 1) ? $clog2(CELL_COLUMNS) : 1;
  localparam int CROW_W   = (CELL_ROWS > 1) ? $clog2(CELL_ROWS) : 1;

  localparam logic [6:0] SPACE_CHAR = 7'h20;

  typedef enum logic [1:0] {
    MODE_CELL    = 2'd0,
    MODE_GLYPH   = 2'd1,
    MODE_PALETTE = 2'd2,
    MODE_PIXEL   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  localparam logic [11:0] DEFAULT_PALETTE [PALETTE_SIZE] = '{
    12'h000, 12'h00A, 12'h0A0, 12'h0AA, 12'hA00, 12'hA0A, 12'hA50, 12'hAAA,
    12'h555, 12'h55F, 12'h5F5, 12'h5FF, 12'hF55, 12'hF5F, 12'hFF5, 12'hFFF
  };

  // Item after the cell read has been issued.
  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  address;
    logic [15:0] value;
    logic [1:0]  px;
    logic [2:0]  py;
    logic        last;
  } s1_t;

  // Item after the glyph read has been issued.
  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  address;
    logic [15:0] value;
    logic [3:0]  bit_sel;
    logic        ch_ok;
    logic [3:0]  fg;
    logic [3:0]  bg;
    logic        last;
  } s2_t;

endpackage

`default_nettype wire

// File: hdl/tmpg_if.sv
// Valid/ready channel interfaces for the text mode pixel generator:
// one for command beats in, one for pixel beats out. No dependencies.
`default_nettype none

interface tmpg_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [8:0]  address;
  logic [15:0] value;

  modport source (output valid, mode, address, value, input ready);
  modport sink   (input valid, mode, address, value, output ready);
endinterface

interface tmpg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_last;

  modport source (output valid, red, green, blue, frame_last, input ready);
  modport sink   (input valid, red, green, blue, frame_last, output ready);
endinterface

`default_nettype wire

// File: hdl/tmpg_ram.sv
// Generic simple dual port RAM: one write port, one read port with a
// registered read that holds while the read enable is low. No dependencies.
`default_nettype none

module tmpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/text_mode_pixel_generator_top.sv
// Top level of the text mode pixel generator.
// Depends on tmpg_pkg, tmpg_in_if / tmpg_out_if and tmpg_ram.
`default_nettype none

// Text mode pixel generator. Each command beat either writes a screen cell,
// a glyph word or a palette entry, or asks for the next pixel in raster
// order; only pixel requests produce an output beat. The block takes one
// beat per clock while the output is not stalled. A pixel request passes
// the cell RAM read at the accepting edge, then the glyph RAM read, then
// the palette lookup into the output register. A stalled output backs up
// the pipeline one stage at a time, so write beats and pixel requests keep
// flowing into the empty stages. After reset the block sweeps the screen
// RAM once, all CELL_TOTAL (384 with the default geometry) cells, to load
// the default quadrant colours; while it sweeps, the input is not ready.
// Glyph words hold garbage until written, so draw only characters whose
// glyphs have been loaded.

module text_mode_pixel_generator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tmpg_in_if.sink   in_i,
  tmpg_out_if.source out_o
);

  localparam int CELL_AW  = tmpg_pkg::CELL_AW;
  localparam int GLYPH_AW = tmpg_pkg::GLYPH_AW;
  localparam int COL_W    = tmpg_pkg::COL_W;
  localparam int ROW_W    = tmpg_pkg::ROW_W;
  localparam int CCOL_W   = tmpg_pkg::CCOL_W;
  localparam int CROW_W   = tmpg_pkg::CROW_W;

  // ---------------------------------------------------------------------
  // Pipeline flow control. Stage 1 waits on the cell read, stage 2 on the
  // glyph read, then the output register. Write beats fall out at stage 2.
  // ---------------------------------------------------------------------
  tmpg_pkg::state_e state_q, state_d;
  logic             run;

  logic             v1_q, v2_q, out_v_q;
  tmpg_pkg::s1_t    s1_q, s1_d;
  tmpg_pkg::s2_t    s2_q, s2_d;

  logic out_free, go2, ld2, go1, ld1, accept;

  assign run      = (state_q == tmpg_pkg::ST_RUN);
  assign out_free = !out_v_q || out_o.ready;
  assign go2      = v2_q && ((s2_q.mode != tmpg_pkg::MODE_PIXEL) || out_free);
  assign ld2      = !v2_q || go2;
  assign go1      = v1_q && ld2;
  assign ld1      = !v1_q || go1;
  assign in_i.ready = run && ld1;
  assign accept   = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------
  // Clearing sweep: load every cell with a space, foreground 0 and the
  // screen quadrant as background.
  // ---------------------------------------------------------------------
  logic [CELL_AW-1:0] clr_addr_q;
  logic [CCOL_W-1:0]  clr_col_q;
  logic [CROW_W-1:0]  clr_row_q;
  logic               qc, qr;
  logic [15:0]        clr_data;
  logic               clr_done;

  assign qc       = (32'(clr_col_q) * 2) >= tmpg_pkg::CELL_COLUMNS;
  assign qr       = (32'(clr_row_q) * 2) >= tmpg_pkg::CELL_ROWS;
  assign clr_data = {4'h0, 2'b00, qr, qc, 1'b0, tmpg_pkg::SPACE_CHAR};
  assign clr_done = (32'(clr_addr_q) == tmpg_pkg::CELL_TOTAL - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmpg_pkg::ST_CLEAR: if (clr_done) state_d = tmpg_pkg::ST_RUN;
      tmpg_pkg::ST_RUN:   state_d = tmpg_pkg::ST_RUN;
      default:            state_d = tmpg_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tmpg_pkg::ST_CLEAR;
      clr_addr_q <= '0;
      clr_col_q  <= '0;
      clr_row_q  <= '0;
    end else begin
      state_q <= state_d;
      if (!run) begin
        // Advance the sweep position along rows of cells.
        clr_addr_q <= clr_addr_q + 1'b1;
        if (32'(clr_col_q) == tmpg_pkg::CELL_COLUMNS - 1) begin
          clr_col_q <= '0;
          clr_row_q <= clr_row_q + 1'b1;
        end else begin
          clr_col_q <= clr_col_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Raster position of the next pixel; advance on each accepted request.
  // ---------------------------------------------------------------------
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             col_end, row_end, pix_req;

  assign col_end = (col_q == COL_W'(tmpg_pkg::PIXEL_COLUMNS - 1));
  assign row_end = (row_q == ROW_W'(tmpg_pkg::PIXEL_ROWS - 1));
  assign pix_req = accept && (in_i.mode == tmpg_pkg::MODE_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_req) begin
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Screen cell RAM: written by the sweep or by cell beats at accept, read
  // at accept for pixel requests.
  // ---------------------------------------------------------------------
  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr, cell_raddr;
  logic [15:0]        cell_wdata, cell_rdata;

  always_comb begin
    if (!run) begin
      cell_we    = 1'b1;
      cell_waddr = clr_addr_q;
      cell_wdata = clr_data;
    end else begin
      cell_we    = accept && (in_i.mode == tmpg_pkg::MODE_CELL)
                   && (32'(in_i.address) < tmpg_pkg::CELL_TOTAL);
      cell_waddr = CELL_AW'(in_i.address);
      cell_wdata = in_i.value;
    end
  end

  assign cell_raddr = CELL_AW'(col_q >> 2)
                    + CELL_AW'(tmpg_pkg::CELL_COLUMNS) * CELL_AW'(row_q >> 3);

  tmpg_ram #(
    .WIDTH (16),
    .DEPTH (tmpg_pkg::CELL_TOTAL)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .re_i    (pix_req),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  always_comb begin
    s1_d.mode    = in_i.mode;
    s1_d.address = in_i.address;
    s1_d.value   = in_i.value;
    s1_d.px      = col_q[1:0];
    s1_d.py      = row_q[2:0];
    s1_d.last    = col_end && row_end;
  end

  // ---------------------------------------------------------------------
  // Glyph RAM: written as glyph beats leave stage 1, read for pixels there.
  // ---------------------------------------------------------------------
  logic [6:0]          ch;
  logic                glyph_we, glyph_re;
  logic [GLYPH_AW-1:0] glyph_raddr;
  logic [15:0]         glyph_rdata;

  assign ch          = cell_rdata[6:0];
  assign glyph_we    = go1 && (s1_q.mode == tmpg_pkg::MODE_GLYPH)
                       && (32'(s1_q.address) < tmpg_pkg::GLYPH_WORDS);
  assign glyph_re    = go1 && (s1_q.mode == tmpg_pkg::MODE_PIXEL);
  assign glyph_raddr = GLYPH_AW'({ch, s1_q.px[1]});

  tmpg_ram #(
    .WIDTH (16),
    .DEPTH (tmpg_pkg::GLYPH_WORDS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (glyph_we),
    .waddr_i (GLYPH_AW'(s1_q.address)),
    .wdata_i (s1_q.value),
    .re_i    (glyph_re),
    .raddr_i (glyph_raddr),
    .rdata_o (glyph_rdata)
  );

  always_comb begin
    s2_d.mode    = s1_q.mode;
    s2_d.address = s1_q.address;
    s2_d.value   = s1_q.value;
    // Even columns live in the high byte, odd in the low byte.
    s2_d.bit_sel = {~s1_q.px[0], s1_q.py};
    s2_d.ch_ok   = 32'(ch) < tmpg_pkg::GLYPH_COUNT;
    s2_d.fg      = cell_rdata[15:12];
    s2_d.bg      = cell_rdata[11:8];
    s2_d.last    = s1_q.last;
  end

  // ---------------------------------------------------------------------
  // Palette in flops: written as palette beats leave stage 2, looked up
  // for pixels there.
  // ---------------------------------------------------------------------
  logic [11:0] pal_q [tmpg_pkg::PALETTE_SIZE];
  logic        pal_we, glyph_set;
  logic [3:0]  pal_idx;
  logic [11:0] colour;

  assign pal_we    = go2 && (s2_q.mode == tmpg_pkg::MODE_PALETTE)
                     && (32'(s2_q.address) < tmpg_pkg::PALETTE_SIZE);
  assign glyph_set = s2_q.ch_ok && glyph_rdata[s2_q.bit_sel];
  assign pal_idx   = glyph_set ? s2_q.fg : s2_q.bg;
  assign colour    = pal_q[pal_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tmpg_pkg::PALETTE_SIZE; i++) begin
        pal_q[i] <= tmpg_pkg::DEFAULT_PALETTE[i];
      end
    end else if (pal_we) begin
      pal_q[s2_q.address[3:0]] <= s2_q.value[11:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stage valids and payload registers.
  // ---------------------------------------------------------------------
  logic       out_load;
  logic [7:0] red_q, green_q, blue_q;
  logic       last_q;

  assign out_load = go2 && (s2_q.mode == tmpg_pkg::MODE_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= accept;
      if (ld2) v2_q <= v1_q;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) s1_q <= s1_d;
    if (go1)    s2_q <= s2_d;
    if (out_load) begin
      // Double each nibble to a full byte.
      red_q   <= {colour[11:8], colour[11:8]};
      green_q <= {colour[7:4], colour[7:4]};
      blue_q  <= {colour[3:0], colour[3:0]};
      last_q  <= s2_q.last;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.red        = red_q;
  assign out_o.green      = green_q;
  assign out_o.blue       = blue_q;
  assign out_o.frame_last = last_q;

endmodule

`default_nettype wire
